### design/acs_pkg.sv
package acs_pkg;

  // Fixed field widths
  localparam int AXIS_W   = 2;
  localparam int SAMPLE_W = 12;
  localparam int WIDE_W   = 16;
  localparam int VALUE_W  = 16;
  localparam int GAIN_W   = 32;
  localparam int PROD_W   = WIDE_W + GAIN_W;

  // Full-scale numerators of the gain division
  localparam logic [WIDE_W-1:0] FULL_POS = 16'h7FFF;
  localparam logic [WIDE_W-1:0] FULL_NEG = 16'h8000;

  // Saturation limits of the scaled value
  localparam logic [VALUE_W-1:0] SAT_POS = 16'h7FFF;
  localparam logic [VALUE_W-1:0] SAT_NEG = 16'h8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEV,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } acs_state_t;

  typedef struct packed {
    logic accept;     // latch the input word
    logic calc;       // form deviation, update tracking state
    logic div_start;  // launch both gain divisions
    logic gain_wr;    // store the division results
    logic mul;        // register deviation times gain
    logic out_load;   // load the output register
  } acs_cmd_t;

  typedef struct packed {
    logic zero_out;   // result is zero: held or axis out of range
    logic release_cal;// released word that ends calibration
    logic div_done;   // both divisions finished
    logic out_busy;   // output register full and not taken
  } acs_status_t;

endpackage

### design/acs_div.sv
module acs_div #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import acs_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] num;
  logic [15:0]   rem;
  logic [15:0]   dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [16:0]   trial;
  logic          ge;
  logic [16:0]   diff;

  // One quotient bit per cycle, restoring form
  assign trial = {rem, num[DW-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[15:0] : trial[15:0];
      num <= {num[DW-2:0], ge};
    end
  end

  assign quotient = num;

endmodule

### design/acs_ctrl.sv
module acs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  acs_pkg::acs_status_t status,
  output acs_pkg::acs_cmd_t    cmd
);
  import acs_pkg::*;

  acs_state_t state;
  acs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DEV;
      end
      ST_DEV: begin
        if (status.zero_out)         state_next = ST_FIN;
        else if (status.release_cal) state_next = ST_DIV;
        else                         state_next = ST_MUL;
      end
      ST_DIV: begin
        if (status.div_done) state_next = ST_MUL;
      end
      ST_MUL: state_next = ST_FIN;
      ST_FIN: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_DEV: begin
        cmd.calc      = 1'b1;
        cmd.div_start = !status.zero_out && status.release_cal;
      end
      ST_DIV:  cmd.gain_wr = status.div_done;
      ST_MUL:  cmd.mul = 1'b1;
      ST_FIN:  cmd.out_load = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

### design/acs_dp.sv
module acs_dp #(
  parameter int AXES           = 4,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  acs_pkg::acs_cmd_t    cmd,
  output acs_pkg::acs_status_t status,
  input  logic [15:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,
  output logic [1:0]           m_tuser
);
  import acs_pkg::*;

  localparam int IW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int DW = WIDE_W + GAIN_FRAC_BITS;
  localparam int MW = PROD_W - GAIN_FRAC_BITS;
  localparam logic [DW-1:0]     POS_NUM  = DW'(FULL_POS) << GAIN_FRAC_BITS;
  localparam logic [DW-1:0]     NEG_NUM  = DW'(FULL_NEG) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;

  // Per-axis state
  logic [WIDE_W-1:0] center   [AXES];
  logic [GAIN_W-1:0] pos_gain [AXES];
  logic [GAIN_W-1:0] neg_gain [AXES];
  logic [WIDE_W-1:0] dev_max  [AXES];  // largest positive deviation
  logic [WIDE_W-1:0] dev_min  [AXES];  // magnitude of most negative deviation
  logic [AXES-1:0]   calibrating;

  // Word under work
  logic [AXIS_W-1:0] axis_r;
  logic [WIDE_W-1:0] w_r;
  logic              held_r;
  logic [IW-1:0]     idx;
  logic              in_range;

  logic [16:0]       dev;
  logic              dev_pos;
  logic              dev_neg;
  logic [WIDE_W-1:0] dev_abs;

  logic              d_pos;
  logic [WIDE_W-1:0] d_mag;
  logic              zero_r;
  logic              done_r;
  logic              err_r;
  logic              zero_ext;

  logic [WIDE_W-1:0] div_pos;
  logic [WIDE_W-1:0] div_neg;
  logic              pdone;
  logic              ndone;
  logic [DW-1:0]     pquo;
  logic [DW-1:0]     nquo;
  logic [47:0]       pquo_x;
  logic [47:0]       nquo_x;
  logic [GAIN_W-1:0] pgain_new;
  logic [GAIN_W-1:0] ngain_new;

  logic [GAIN_W-1:0] gain_sel;
  logic [PROD_W-1:0] prod;
  logic [MW-1:0]     mag;
  logic [VALUE_W-1:0] mag_neg;
  logic [VALUE_W-1:0] value;

  assign idx      = IW'(axis_r);
  assign in_range = int'(axis_r) < AXES;

  // Deviation from the stored center, 17-bit two's complement
  assign dev     = {1'b0, w_r} - {1'b0, center[idx]};
  assign dev_neg = dev[16];
  assign dev_pos = !dev[16] && (dev != '0);
  assign dev_abs = dev_neg ? 16'(-dev) : dev[15:0];

  assign zero_ext = (dev_max[idx] == '0) || (dev_min[idx] == '0);
  assign div_pos  = zero_ext ? WIDE_W'(1) : dev_max[idx];
  assign div_neg  = zero_ext ? WIDE_W'(1) : dev_min[idx];

  assign status.zero_out    = !in_range || held_r;
  assign status.release_cal = in_range && !held_r && calibrating[idx];
  assign status.div_done    = pdone && ndone;
  assign status.out_busy    = m_tvalid && !m_tready;

  acs_div #(.DW(DW)) u_div_pos (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (POS_NUM),
    .divisor  (div_pos),
    .done     (pdone),
    .quotient (pquo)
  );

  acs_div #(.DW(DW)) u_div_neg (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (NEG_NUM),
    .divisor  (div_neg),
    .done     (ndone),
    .quotient (nquo)
  );

  // Clamp quotients that overflow 32 bits
  assign pquo_x    = 48'(pquo);
  assign nquo_x    = 48'(nquo);
  assign pgain_new = (|pquo_x[47:32]) ? '1 : pquo_x[31:0];
  assign ngain_new = (|nquo_x[47:32]) ? '1 : nquo_x[31:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      axis_r <= s_tuser;
      w_r    <= {s_tdata[11:0], 4'b0000};
      held_r <= s_tdata[12];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      d_pos  <= dev_pos;
      d_mag  <= dev_abs;
      zero_r <= status.zero_out;
      done_r <= status.release_cal;
      err_r  <= status.release_cal && zero_ext;
    end
    if (cmd.mul) begin
      prod <= d_mag * gain_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrating <= '0;
      for (int i = 0; i < AXES; i++) begin
        center[i]   <= FULL_NEG;
        pos_gain[i] <= GAIN_ONE;
        neg_gain[i] <= GAIN_ONE;
        dev_max[i]  <= '0;
        dev_min[i]  <= '0;
      end
    end else begin
      if (cmd.calc && in_range && held_r) begin
        if (!calibrating[idx]) begin
          // first held word: take it as the center, restart tracking
          calibrating[idx] <= 1'b1;
          center[idx]      <= w_r;
          dev_max[idx]     <= '0;
          dev_min[idx]     <= '0;
        end else begin
          if (dev_pos && dev_abs > dev_max[idx]) dev_max[idx] <= dev_abs;
          if (dev_neg && dev_abs > dev_min[idx]) dev_min[idx] <= dev_abs;
        end
      end
      if (cmd.div_start) begin
        calibrating[idx] <= 1'b0;
      end
      if (cmd.gain_wr) begin
        pos_gain[idx] <= pgain_new;
        neg_gain[idx] <= ngain_new;
      end
    end
  end

  assign gain_sel = d_pos ? pos_gain[idx] : neg_gain[idx];

  // Drop fraction bits, saturate, apply sign
  assign mag     = prod[PROD_W-1:GAIN_FRAC_BITS];
  assign mag_neg = (mag > MW'(SAT_NEG)) ? SAT_NEG : mag[VALUE_W-1:0];

  always_comb begin
    priority if (zero_r) begin
      value = '0;
    end else if (d_pos) begin
      value = (mag > MW'(SAT_POS)) ? SAT_POS : mag[VALUE_W-1:0];
    end else begin
      value = VALUE_W'(0) - mag_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= axis_r;
      m_tdata <= {6'b000000, err_r, done_r, value};
    end
  end

endmodule

### design/axis_calibrate_scale_unit.sv
// Channel  Direction  Payload
// -------  ---------  ------------------------------------------------------
// s_*      in         tuser: axis_sel[1:0]; tdata: sample[11:0], cal_held[12]
// m_*      out        tuser: axis_out[1:0];
//                     tdata: scaled_value[15:0], cal_done[16], cal_error[17]
//
// Steps: accept, deviation, multiply, output load per word; a held or
// out-of-range word skips the multiply; a release word adds the gain divisions.
// Reset: synchronous rst sets centers to mid scale, gains to 1.0, clears
// tracking and the output valid flag.
// Stalls: a finished word waits in the output register while the next input
// word is taken; output load holds only while that register is still full.
module axis_calibrate_scale_unit #(
  parameter int AXES           = 4,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // sample[11:0], cal_held[12], zero pad
  input  logic [1:0]  s_tuser,   // axis_sel[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // scaled_value[15:0], cal_done[16], cal_error[17], pad
  output logic [1:0]  m_tuser    // axis_out[1:0]
);
  import acs_pkg::*;

  acs_cmd_t    cmd;
  acs_status_t status;

  // Sequence one word at a time through the datapath
  acs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold per-axis calibration state, dividers, multiplier, output register
  acs_dp #(
    .AXES           (AXES),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### verif/tb_top.sv
module tb_top;
  import acs_pkg::*;

  localparam int NUM_AXES  = 4;
  localparam int FRAC_BITS = 16;
  localparam int RANDOM_WORDS = 500;
  localparam int DRAIN_CYCLES = 60;

  // row kinds and button levels of the stimulus table
  localparam bit TYPED = 1'b1;
  localparam bit PRED  = 1'b0;
  localparam int HELD  = 1;
  localparam int FREE  = 0;

  typedef struct packed {
    logic [AXIS_W-1:0]  axis;
    logic [VALUE_W-1:0] value;
    logic               done;
    logic               err;
  } result_t;

  typedef struct {
    int axis;
    int sample;
    int held;
    bit typed;
    int value;
    int done;
    int err;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  // calibration state mirrored per axis
  logic [WIDE_W-1:0]  pred_center     [NUM_AXES];
  logic [GAIN_W-1:0]  cal_pos_gain    [NUM_AXES];
  logic [GAIN_W-1:0]  cal_neg_gain    [NUM_AXES];
  logic signed [16:0] cal_dev_max     [NUM_AXES];
  logic signed [16:0] cal_dev_min     [NUM_AXES];
  logic               cal_active      [NUM_AXES];

  result_t expected_words [$];
  int      mismatches = 0;
  bit      tx_steady = 1'b0;
  bit      rx_steady = 1'b0;

  // Directed words: plain scaling after reset, a calibration with no movement,
  // a full-range calibration, one-sided ones (max stuck at zero, min stuck at
  // zero) and saturation at both ends of the output range.
  stim_row_t dir_rows [25] = '{
    '{0, 2048, FREE, TYPED,      0, 0, 0},
    '{0, 4095, FREE, TYPED,  32752, 0, 0},
    '{0,    0, FREE, TYPED, -32768, 0, 0},
    '{2, 1000, HELD, TYPED,      0, 0, 0},
    '{2, 1000, HELD, TYPED,      0, 0, 0},
    '{2, 1000, FREE, TYPED,      0, 1, 1},
    '{2, 1500, FREE, PRED,       0, 0, 0},
    '{2,  500, FREE, PRED,       0, 0, 0},
    '{1, 2048, HELD, TYPED,      0, 0, 0},
    '{1, 3000, HELD, TYPED,      0, 0, 0},
    '{1, 1000, HELD, TYPED,      0, 0, 0},
    '{1, 4095, HELD, TYPED,      0, 0, 0},
    '{1,    0, HELD, TYPED,      0, 0, 0},
    '{1, 2048, FREE, TYPED,      0, 1, 0},
    '{1, 4095, FREE, PRED,       0, 0, 0},
    '{1,    0, FREE, PRED,       0, 0, 0},
    '{1, 2500, FREE, PRED,       0, 0, 0},
    '{3, 2048, HELD, TYPED,      0, 0, 0},
    '{3, 3000, HELD, TYPED,      0, 0, 0},
    '{3, 2048, FREE, TYPED,      0, 1, 1},
    '{3, 4095, FREE, TYPED,  32767, 0, 0},
    '{0, 4095, HELD, TYPED,      0, 0, 0},
    '{0,    0, HELD, TYPED,      0, 0, 0},
    '{0, 4095, FREE, TYPED,      0, 1, 1},
    '{0,    0, FREE, TYPED, -32768, 0, 0}
  };

  axis_calibrate_scale_unit #(
    .AXES          (NUM_AXES),
    .GAIN_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [GAIN_W-1:0] gain_quotient(longint unsigned full_scale,
                                                      longint unsigned divisor);
    longint unsigned q;
    q = (full_scale << FRAC_BITS) / divisor;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // Advance the calibration state by one word and return the value it yields.
  function automatic result_t calibrate_and_scale(logic [1:0] axis, logic [11:0] sample,
                                                  logic held);
    result_t         r;
    logic [15:0]     wide;
    int              dev;
    int              mx;
    int              mn;
    longint unsigned mag;
    r.axis  = axis;
    r.value = '0;
    r.done  = 1'b0;
    r.err   = 1'b0;
    wide = {sample, 4'b0000};
    dev  = int'(wide) - int'(pred_center[axis]);
    if (held) begin
      if (!cal_active[axis]) begin
        cal_active[axis]  = 1'b1;
        pred_center[axis] = wide;
        cal_dev_max[axis] = '0;
        cal_dev_min[axis] = '0;
      end else begin
        if (dev > int'(cal_dev_max[axis])) cal_dev_max[axis] = 17'(dev);
        if (dev < int'(cal_dev_min[axis])) cal_dev_min[axis] = 17'(dev);
      end
      return r;
    end
    if (cal_active[axis]) begin
      mx = int'(cal_dev_max[axis]);
      mn = int'(cal_dev_min[axis]);
      cal_active[axis] = 1'b0;
      // a side that never moved gets unit deviation and flags the error
      if (mx == 0 || mn == 0) begin
        mx    = 1;
        mn    = -1;
        r.err = 1'b1;
      end
      cal_pos_gain[axis] = gain_quotient(64'd32767, longint'(mx));
      cal_neg_gain[axis] = gain_quotient(64'd32768, longint'(-mn));
      r.done = 1'b1;
    end
    if (dev > 0) begin
      mag = (longint'(dev) * longint'(cal_pos_gain[axis])) >> FRAC_BITS;
      if (mag > 32767) mag = 32767;
      r.value = mag[15:0];
    end else begin
      mag = (longint'(-dev) * longint'(cal_neg_gain[axis])) >> FRAC_BITS;
      if (mag > 32768) mag = 32768;
      r.value = 16'(65536 - mag);
    end
    return r;
  endfunction

  // Present one word, hold it until taken, then queue what it should yield.
  task automatic send_word(input logic [1:0] axis, input logic [11:0] sample,
                           input logic held, input bit typed, input result_t typed_word);
    result_t predicted;
    while (!tx_steady && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= axis;
    s_tdata  <= {3'b000, held, sample};
    do @(posedge clk); while (!s_tready);
    predicted = calibrate_and_scale(axis, sample, held);
    expected_words.push_back(typed ? typed_word : predicted);
  endtask

  // Result side: stall at random unless rx_steady is set, and check every word taken.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= rx_steady || ($urandom_range(99) >= 31);
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: axis_out %0d scaled_value %0d", m_tuser,
                 $signed(m_tdata[15:0]));
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (m_tuser !== want.axis) begin
            $error("axis_out: expected %0d, actual %0d", want.axis, m_tuser);
            mismatches++;
          end
          if (m_tdata[15:0] !== want.value) begin
            $error("scaled_value: expected %0d, actual %0d", $signed(want.value),
                   $signed(m_tdata[15:0]));
            mismatches++;
          end
          if (m_tdata[16] !== want.done) begin
            $error("cal_done: expected %0d, actual %0d", want.done, m_tdata[16]);
            mismatches++;
          end
          if (m_tdata[17] !== want.err) begin
            $error("cal_error: expected %0d, actual %0d", want.err, m_tdata[17]);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[axis_calibrate_scale_unit] ERROR");
    $finish;
  end

  initial begin
    result_t     typed_word;
    logic        button [NUM_AXES];
    logic [1:0]  axis;
    logic [11:0] smp;
    logic        held;
    int          roll;

    for (int a = 0; a < NUM_AXES; a++) begin
      pred_center[a]  = 16'h8000;
      cal_pos_gain[a] = 32'(1) << FRAC_BITS;
      cal_neg_gain[a] = 32'(1) << FRAC_BITS;
      cal_dev_max[a]  = '0;
      cal_dev_min[a]  = '0;
      cal_active[a]   = 1'b0;
      button[a]       = 1'b0;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      typed_word.axis  = 2'(dir_rows[i].axis);
      typed_word.value = 16'(dir_rows[i].value);
      typed_word.done  = 1'(dir_rows[i].done);
      typed_word.err   = 1'(dir_rows[i].err);
      send_word(2'(dir_rows[i].axis), 12'(dir_rows[i].sample), 1'(dir_rows[i].held),
                dir_rows[i].typed, typed_word);
    end

    // Random part: mostly per-axis hold/release sequences, some stray button levels.
    typed_word = '0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // drop valid and let every queued word come back before going on
      if (n == 100) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
      end
      tx_steady = (n >= 200 && n < 320);
      rx_steady = (n >= 200 && n < 320);

      axis = 2'($urandom_range(NUM_AXES - 1));
      roll = $urandom_range(99);
      if (button[axis]) button[axis] = (roll >= 30);
      else              button[axis] = (roll < 12);
      held = button[axis];
      if ($urandom_range(99) < 8) held = 1'($urandom_range(1));

      case ($urandom_range(7))
        0:       smp = 12'd0;
        1:       smp = 12'd4095;
        2:       smp = 12'($urandom_range(2052, 2044));
        default: smp = 12'($urandom_range(4095));
      endcase
      send_word(axis, smp, held, PRED, typed_word);
    end
    s_tvalid <= 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[axis_calibrate_scale_unit] OK");
    end else begin
      $display("[axis_calibrate_scale_unit] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
design/acs_pkg.sv
design/acs_div.sv
design/acs_ctrl.sv
design/acs_dp.sv
design/axis_calibrate_scale_unit.sv
verif/tb_top.sv
